// ===== hdl/qlst_pkg.sv =====
// Shared widths, constants and types of the quad light sensor tracker step.
package qlst_pkg;

	localparam int ANGLE_W = 8;
	localparam int BAND_W  = 7;
	localparam int DELAY_W = 7;

	localparam int LEVEL_LOW  = 10;
	localparam int LEVEL_HIGH = 300;
	localparam int OFFSET_W   = 9;

	localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd90;
	localparam logic [ANGLE_W-1:0] MAX_ANGLE  = 8'd180;
	localparam logic [ANGLE_W-1:0] MIN_ANGLE  = 8'd0;

	localparam logic [BAND_W-1:0]  BAND_MIN      = 7'd5;
	localparam logic [BAND_W-1:0]  BAND_MAX      = 7'd100;
	localparam logic [DELAY_W-1:0] DELAY_SLOW    = 7'd100;
	localparam logic [DELAY_W-1:0] DELAY_FAST    = 7'd50;
	localparam logic [BAND_W-1:0]  OUTSIDE_BAND  = 7'd50;
	localparam logic [DELAY_W-1:0] OUTSIDE_DELAY = 7'd50;

	// Scaled reciprocal of the level span: ceil(2^24 / 290), folded with the slopes.
	localparam int RECIP_SHIFT = 24;
	localparam logic [31:0] SPAN_RECIP  = 32'd57853;
	localparam logic [31:0] BAND_RECIP  = 32'(95) * SPAN_RECIP;
	localparam logic [31:0] DELAY_RECIP = 32'(50) * SPAN_RECIP;

	typedef struct packed {
		logic [BAND_W-1:0]  deadband;
		logic [DELAY_W-1:0] settle_delay_ms;
	} map_t;

endpackage

// ===== hdl/qlst_sample_if.sv =====
// Request channel carrying one set of four light samples.
interface qlst_sample_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] light_top_left;
	logic [SAMPLE_BITS-1:0] light_top_right;
	logic [SAMPLE_BITS-1:0] light_bottom_left;
	logic [SAMPLE_BITS-1:0] light_bottom_right;

	modport source (
		output valid, light_top_left, light_top_right, light_bottom_left, light_bottom_right,
		input  ready
	);
	modport sink (
		input  valid, light_top_left, light_top_right, light_bottom_left, light_bottom_right,
		output ready
	);
endinterface

// ===== hdl/qlst_result_if.sv =====
// Result channel carrying the new angles, the deadband and the settle delay.
interface qlst_result_if;
	logic                          valid;
	logic                          ready;
	logic [qlst_pkg::ANGLE_W-1:0]  vertical_angle;
	logic [qlst_pkg::ANGLE_W-1:0]  horizontal_angle;
	logic [qlst_pkg::BAND_W-1:0]   deadband;
	logic [qlst_pkg::DELAY_W-1:0]  settle_delay_ms;

	modport source (
		output valid, vertical_angle, horizontal_angle, deadband, settle_delay_ms,
		input  ready
	);
	modport sink (
		input  valid, vertical_angle, horizontal_angle, deadband, settle_delay_ms,
		output ready
	);
endinterface

// ===== hdl/quad_light_sensor_tracker_step_core.sv =====
// Top level of the quad light sensor tracker step: input stage, step logic and result stage.
//
//  Channel  Direction  Carries
//  sample   in         four light samples per request
//  result   out        vertical and horizontal angle, deadband, settle delay
//
// Each request is registered in the input stage and then moves on to the result stage, from which
// its result is offered; one request is taken every cycle while results are taken as offered.
// The position registers are updated as a request moves into the result stage.
// Reset puts both positions at 90 degrees and empties both stages.
// A stalled result holds; the input stage still takes a request while it is empty.
module quad_light_sensor_tracker_step_core #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	qlst_sample_if.sink   sample,
	qlst_result_if.source result
);
	import qlst_pkg::*;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] tl_s1;
	logic [SAMPLE_BITS-1:0] tr_s1;
	logic [SAMPLE_BITS-1:0] bl_s1;
	logic [SAMPLE_BITS-1:0] br_s1;

	logic                   valid_s2;
	logic [ANGLE_W-1:0]     vert_s2;
	logic [ANGLE_W-1:0]     horz_s2;
	logic [BAND_W-1:0]      band_s2;
	logic [DELAY_W-1:0]     delay_s2;

	logic [ANGLE_W-1:0]     vert_pos_q;
	logic [ANGLE_W-1:0]     horz_pos_q;

	logic                   advance;
	logic                   take;
	logic [SAMPLE_BITS:0]   top_sum;
	logic [SAMPLE_BITS:0]   bottom_sum;
	logic [SAMPLE_BITS:0]   left_sum;
	logic [SAMPLE_BITS:0]   right_sum;
	logic [SAMPLE_BITS:0]   level_sum;
	logic [SAMPLE_BITS-1:0] top_avg;
	logic [SAMPLE_BITS-1:0] bottom_avg;
	logic [SAMPLE_BITS-1:0] left_avg;
	logic [SAMPLE_BITS-1:0] right_avg;
	logic [SAMPLE_BITS-1:0] level;
	logic signed [SAMPLE_BITS:0] dv;
	logic signed [SAMPLE_BITS:0] dh;
	map_t                   map;
	logic [ANGLE_W-1:0]     vert_next;
	logic [ANGLE_W-1:0]     horz_next;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	assign top_sum    = {1'b0, tl_s1} + {1'b0, tr_s1};
	assign bottom_sum = {1'b0, bl_s1} + {1'b0, br_s1};
	assign left_sum   = {1'b0, tl_s1} + {1'b0, bl_s1};
	assign right_sum  = {1'b0, tr_s1} + {1'b0, br_s1};
	assign top_avg    = top_sum[SAMPLE_BITS:1];
	assign bottom_avg = bottom_sum[SAMPLE_BITS:1];
	assign left_avg   = left_sum[SAMPLE_BITS:1];
	assign right_avg  = right_sum[SAMPLE_BITS:1];
	assign level_sum  = {1'b0, top_avg} + {1'b0, bottom_avg};
	assign level      = level_sum[SAMPLE_BITS:1];
	assign dv         = $signed({1'b0, top_avg}) - $signed({1'b0, bottom_avg});
	assign dh         = $signed({1'b0, left_avg}) - $signed({1'b0, right_avg});

	qlst_level_map #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_level_map (
		.level(level),
		.map  (map)
	);

	qlst_axis_step #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_vert_step (
		.diff    (dv),
		.band    (map.deadband),
		.pos     (vert_pos_q),
		.pos_next(vert_next)
	);

	qlst_axis_step #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_horz_step (
		.diff    (dh),
		.band    (map.deadband),
		.pos     (horz_pos_q),
		.pos_next(horz_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			vert_pos_q <= HOME_ANGLE;
			horz_pos_q <= HOME_ANGLE;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				valid_s2   <= 1'b1;
				vert_pos_q <= vert_next;
				horz_pos_q <= horz_next;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tl_s1 <= sample.light_top_left;
			tr_s1 <= sample.light_top_right;
			bl_s1 <= sample.light_bottom_left;
			br_s1 <= sample.light_bottom_right;
		end
		if (advance) begin
			vert_s2  <= vert_next;
			horz_s2  <= horz_next;
			band_s2  <= map.deadband;
			delay_s2 <= map.settle_delay_ms;
		end
	end

	assign result.valid            = valid_s2;
	assign result.vertical_angle   = vert_s2;
	assign result.horizontal_angle = horz_s2;
	assign result.deadband         = band_s2;
	assign result.settle_delay_ms  = delay_s2;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vert_pos_q <= MAX_ANGLE && horz_pos_q <= MAX_ANGLE)
		else $error("axis position beyond its upper limit");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vert_pos_q) && $stable(horz_pos_q))
		else $error("axis position moved without a request advancing");

	a_result_matches_pos: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vert_s2 == vert_pos_q && horz_s2 == horz_pos_q)
		else $error("result angles differ from the stored positions");

	a_map_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> band_s2 >= BAND_MIN && band_s2 <= BAND_MAX
			&& delay_s2 >= DELAY_FAST && delay_s2 <= DELAY_SLOW)
		else $error("deadband or settle delay out of range");
`endif
endmodule

// ===== hdl/qlst_level_map.sv =====
// Maps the light level to the deadband and the settle delay.
module qlst_level_map #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic [SAMPLE_BITS-1:0] level,
	output qlst_pkg::map_t         map
);
	import qlst_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;

	logic [CMP_W-1:0]    level_ext;
	logic [CMP_W-1:0]    offset;
	logic [OFFSET_W-1:0] d;
	logic                in_band;
	logic [31:0]         band_prod;
	logic [31:0]         delay_prod;

	assign level_ext  = CMP_W'(level);
	assign in_band    = (level_ext > CMP_W'(LEVEL_LOW)) && (level_ext < CMP_W'(LEVEL_HIGH));
	assign offset     = level_ext - CMP_W'(LEVEL_LOW);
	assign d          = offset[OFFSET_W-1:0];
	assign band_prod  = 32'(d) * BAND_RECIP;
	assign delay_prod = 32'(d) * DELAY_RECIP;

	always_comb begin
		if (in_band) begin
			map.deadband        = BAND_MIN + band_prod[RECIP_SHIFT+BAND_W-1:RECIP_SHIFT];
			map.settle_delay_ms = DELAY_SLOW
				- {1'b0, delay_prod[RECIP_SHIFT+DELAY_W-2:RECIP_SHIFT]};
		end else begin
			map.deadband        = OUTSIDE_BAND;
			map.settle_delay_ms = OUTSIDE_DELAY;
		end
	end
endmodule

// ===== hdl/qlst_axis_step.sv =====
// Steps one axis position by one degree against the deadband and clamps it.
module qlst_axis_step #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic signed [SAMPLE_BITS:0]  diff,
	input  logic [qlst_pkg::BAND_W-1:0]  band,
	input  logic [qlst_pkg::ANGLE_W-1:0] pos,
	output logic [qlst_pkg::ANGLE_W-1:0] pos_next
);
	import qlst_pkg::*;

	logic [SAMPLE_BITS:0]   neg_diff;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   move;

	assign neg_diff = (SAMPLE_BITS+1)'(-diff);
	assign mag      = diff[SAMPLE_BITS] ? neg_diff[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
	assign move     = mag > SAMPLE_BITS'(band);

	always_comb begin
		pos_next = pos;
		if (move) begin
			if (!diff[SAMPLE_BITS]) begin
				if (pos < MAX_ANGLE) begin
					pos_next = pos + ANGLE_W'(1);
				end
			end else if (pos != MIN_ANGLE) begin
				pos_next = pos - ANGLE_W'(1);
			end
		end
	end
endmodule

// ===== test/quad_light_sensor_tracker_step_core_tb.sv =====
// Self-checking testbench for the quad light sensor tracker step core.
module quad_light_sensor_tracker_step_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qlst_pkg::*;

	localparam int SAMPLE_BITS   = 10;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
	localparam int RANDOM_SETS   = 630;
	localparam int DRAIN_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PERCENT  = 24;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] top_left;
		logic [SAMPLE_BITS-1:0] top_right;
		logic [SAMPLE_BITS-1:0] bottom_left;
		logic [SAMPLE_BITS-1:0] bottom_right;
	} light_set_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] vertical;
		logic [ANGLE_W-1:0] horizontal;
		map_t               mapped;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	int   cycle_cnt = 0;
	logic quiet;

	light_set_t pending_q[$];
	angles_t    expected_q[$];

	logic [ANGLE_W-1:0] track_v = HOME_ANGLE;
	logic [ANGLE_W-1:0] track_h = HOME_ANGLE;

	int errors = 0;
	int accepted = 0;
	int checked = 0;
	int limit_holds = 0;
	int outside_sets = 0;

	qlst_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample ();
	qlst_result_if result ();

	quad_light_sensor_tracker_step_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Both sides run flat out for a stretch in the middle of the run.
	assign quiet = (cycle_cnt >= 300) && (cycle_cnt < 600);

	task automatic report_mismatch(string what, int got, int want);
		if (want < 0) begin
			$display("ERROR at %0t: %s (got %0d)", $realtime, what, got);
		end else begin
			$display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		end
		errors++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
		if (v < 0) begin
			return '0;
		end
		if (v > SAMPLE_MAX) begin
			return SAMPLE_BITS'(SAMPLE_MAX);
		end
		return SAMPLE_BITS'(v);
	endfunction

	task automatic queue_set(int tl, int tr, int bl, int br);
		light_set_t s;
		s.top_left     = clip_sample(tl);
		s.top_right    = clip_sample(tr);
		s.bottom_left  = clip_sample(bl);
		s.bottom_right = clip_sample(br);
		pending_q.push_back(s);
	endtask

	function automatic logic [ANGLE_W-1:0] nudge_axis(logic [ANGLE_W-1:0] pos, int diff,
			int band);
		int p;
		p = int'(pos);
		if ((diff < 0 ? -diff : diff) > band) begin
			p += (diff > 0) ? 1 : -1;
		end
		if (p < int'(MIN_ANGLE)) begin
			p = int'(MIN_ANGLE);
			limit_holds++;
		end
		if (p > int'(MAX_ANGLE)) begin
			p = int'(MAX_ANGLE);
			limit_holds++;
		end
		return ANGLE_W'(p);
	endfunction

	// Advances the tracker by one sample set and returns the angles, deadband and settle delay it should report.
	function automatic angles_t step_tracker(light_set_t s);
		int top, bottom, left, right, level, band, delay, offset, span;
		angles_t r;
		top    = (int'(s.top_left) + int'(s.top_right)) / 2;
		bottom = (int'(s.bottom_left) + int'(s.bottom_right)) / 2;
		left   = (int'(s.top_left) + int'(s.bottom_left)) / 2;
		right  = (int'(s.top_right) + int'(s.bottom_right)) / 2;
		level  = (top + bottom) / 2;
		span   = LEVEL_HIGH - LEVEL_LOW;
		if (level > LEVEL_LOW && level < LEVEL_HIGH) begin
			offset = level - LEVEL_LOW;
			band   = int'(BAND_MIN) + offset * (int'(BAND_MAX) - int'(BAND_MIN)) / span;
			delay  = int'(DELAY_SLOW) - offset * (int'(DELAY_SLOW) - int'(DELAY_FAST)) / span;
		end else begin
			band  = int'(OUTSIDE_BAND);
			delay = int'(OUTSIDE_DELAY);
			outside_sets++;
		end
		track_v = nudge_axis(track_v, top - bottom, band);
		track_h = nudge_axis(track_h, left - right, band);
		r.vertical                = track_v;
		r.horizontal              = track_h;
		r.mapped.deadband         = BAND_W'(band);
		r.mapped.settle_delay_ms  = DELAY_W'(delay);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		light_set_t seen;
		light_set_t next_set;
		if (!arst_n) begin
			sample.valid              <= 1'b0;
			sample.light_top_left     <= '0;
			sample.light_top_right    <= '0;
			sample.light_bottom_left  <= '0;
			sample.light_bottom_right <= '0;
		end else begin
			if (sample.valid && sample.ready) begin
				seen.top_left     = sample.light_top_left;
				seen.top_right    = sample.light_top_right;
				seen.bottom_left  = sample.light_bottom_left;
				seen.bottom_right = sample.light_bottom_right;
				expected_q.push_back(step_tracker(seen));
				accepted++;
			end
			if (!sample.valid || sample.ready) begin
				if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
					next_set = pending_q.pop_front();
					sample.valid              <= 1'b1;
					sample.light_top_left     <= next_set.top_left;
					sample.light_top_right    <= next_set.top_right;
					sample.light_bottom_left  <= next_set.bottom_left;
					sample.light_bottom_right <= next_set.bottom_right;
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		angles_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request outstanding, vertical angle",
						result.vertical_angle, -1);
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (result.vertical_angle !== want.vertical) begin
						report_mismatch("vertical angle", result.vertical_angle, want.vertical);
					end
					if (result.horizontal_angle !== want.horizontal) begin
						report_mismatch("horizontal angle", result.horizontal_angle,
							want.horizontal);
					end
					if (result.deadband !== want.mapped.deadband) begin
						report_mismatch("deadband", result.deadband, want.mapped.deadband);
					end
					if (result.settle_delay_ms !== want.mapped.settle_delay_ms) begin
						report_mismatch("settle delay", result.settle_delay_ms,
							want.mapped.settle_delay_ms);
					end
				end
			end
			result.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	initial begin : stimulus
		int made;
		int run_len;
		int dir_v, dir_h;
		int pull_v, pull_h;
		int base, lvl;
		int k;
		int waited;
		logic shaped;

		arst_n <= 1'b0;

		queue_set(0, 0, 0, 0);
		queue_set(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_set(10, 10, 10, 10);
		queue_set(11, 11, 11, 11);
		queue_set(299, 299, 299, 299);
		queue_set(300, 300, 300, 300);
		queue_set(SAMPLE_MAX, SAMPLE_MAX, 0, 0);
		queue_set(0, 0, SAMPLE_MAX, SAMPLE_MAX);
		queue_set(SAMPLE_MAX, 0, SAMPLE_MAX, 0);
		queue_set(0, SAMPLE_MAX, 0, SAMPLE_MAX);
		queue_set(450, 450, 400, 400);
		queue_set(451, 451, 400, 400);
		queue_set(450, 400, 450, 400);
		queue_set(400, 451, 400, 451);
		queue_set(1, 0, 0, 0);
		queue_set(41, 40, 20, 21);
		queue_set(20, 21, 41, 40);
		queue_set(0, SAMPLE_MAX, SAMPLE_MAX, 0);
		queue_set(1022, SAMPLE_MAX, 1, 0);
		queue_set(682, 341, 341, 682);
		queue_set(341, 682, 682, 341);

		// Runs of light, mostly pushing steadily one way, can drive the axes into their limits.
		made = 0;
		while (made < RANDOM_SETS) begin
			run_len = $urandom_range(120, 5);
			dir_v   = int'($urandom_range(2)) - 1;
			dir_h   = int'($urandom_range(2)) - 1;
			shaped  = $urandom_range(9) < 8;
			base    = ($urandom_range(9) < 6) ? $urandom_range(340, 0) : $urandom_range(SAMPLE_MAX, 0);
			for (k = 0; k < run_len && made < RANDOM_SETS; k++) begin
				if (shaped) begin
					pull_v = dir_v * int'($urandom_range(200, 0));
					pull_h = dir_h * int'($urandom_range(200, 0));
					lvl    = base + int'($urandom_range(20, 0)) - 10;
					queue_set(lvl + pull_v + pull_h + int'($urandom_range(8, 0)),
						lvl + pull_v - pull_h + int'($urandom_range(8, 0)),
						lvl - pull_v + pull_h + int'($urandom_range(8, 0)),
						lvl - pull_v - pull_h + int'($urandom_range(8, 0)));
				end else begin
					queue_set($urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0),
						$urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0));
				end
				made++;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0 || sample.valid) @(negedge clk);
		for (waited = 0; expected_q.size() > 0 && waited < DRAIN_LIMIT; waited++) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_q.size() > 0) begin
			report_mismatch("results never delivered", expected_q.size(), 0);
		end

		$display("Summary: %0d sample sets sent, %0d results checked, %0d with mismatches.",
			accepted, checked, errors);
		$display("Summary: %0d axis steps held at an angle limit, %0d sets outside the light band.",
			limit_holds, outside_sets);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Timeout: %0d requests still queued, %0d results outstanding.",
			pending_q.size(), expected_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
